// ===== src/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes for the free list block allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int SIZE_W = 16;
    localparam int OFS_W  = 24;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_NUM_BLOCKS = 1'b1;

    typedef struct packed {
        logic pop;
        logic push;
        logic load;
    } stack_ctrl_t;

endpackage

// ===== src/fbfl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_cell
// One stack entry: shifts up on pop, down on push, loads its index on clear.
// ----------------------------------------------------------------------------
module fbfl_cell
    import fbfl_pkg::*;
#(
    parameter int POS     = 0,
    parameter int RST_CNT = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  stack_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]   n_eff,
    input  logic [IDX_W-1:0]   from_above,
    input  logic [IDX_W-1:0]   from_below,
    output logic [IDX_W-1:0]   value
);

    localparam logic [IDX_W-1:0] RST_VAL = IDX_W'((RST_CNT - 1 - POS) & 255);
    localparam logic [CNT_W-1:0] POS_C   = CNT_W'(POS);

    logic [IDX_W-1:0] value_reg;
    logic [IDX_W-1:0] value_next;
    logic [CNT_W-1:0] load_val;

    assign load_val = n_eff - CNT_W'(1) - POS_C;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_val[IDX_W-1:0];
        end
        else if (ctrl.pop)
        begin
            value_next = from_below;
        end
        else if (ctrl.push)
        begin
            value_next = from_above;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= RST_VAL;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== src/fbfl_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_stack
// Row of cells forming the free index stack, top of stack in cell zero.
// ----------------------------------------------------------------------------
module fbfl_stack
    import fbfl_pkg::*;
#(
    parameter int CELLS   = 256,
    parameter int RST_CNT = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  stack_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]   n_eff,
    input  logic [IDX_W-1:0]   push_idx,
    output logic [IDX_W-1:0]   top_idx
);

    logic [IDX_W-1:0] vals [CELLS];

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        logic [IDX_W-1:0] above;
        logic [IDX_W-1:0] below;

        if (k == 0)
        begin : g_top
            assign above = push_idx;
        end
        else
        begin : g_mid
            assign above = vals[k-1];
        end

        if (k == CELLS - 1)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_up
            assign below = vals[k+1];
        end

        fbfl_cell #(
            .POS     (k),
            .RST_CNT (RST_CNT)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .n_eff      (n_eff),
            .from_above (above),
            .from_below (below),
            .value      (vals[k])
        );
    end

    assign top_idx = vals[0];

endmodule

// ===== src/fixed_block_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Fixed size block allocator with a LIFO free list held in a row of cells.
// ----------------------------------------------------------------------------
// Every action (allocate, free, clear, no-op) takes one item and gives one
// result item in the next cycle; a new item is taken every cycle while the
// result register is empty or being drained. The free list is a chain of
// cells that shift together on pop and push, and a clear reloads every cell
// in the same cycle. The byte offset comes from a single 8 x 16 multiply on
// the top cell. The num_blocks register bounds the free checks at once, but
// the cells are only reloaded from it at the next clear.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // free_index[7:0]
    input  logic [1:0]        s_tuser,   // action[1:0]

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // block_index[7:0], block_offset[31:8],
                                         // used_count[40:32], zero[47:41]
    output logic [1:0]        m_tuser    // status[1:0]
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CELLS   = (MAX_BLOCKS > CNT_MAX) ? CNT_MAX : MAX_BLOCKS;
    localparam int RST_CNT = (MAX_BLOCKS > 256) ? 256 : MAX_BLOCKS;
    localparam logic [CNT_W-1:0] RST_DEPTH = CNT_W'(RST_CNT);
    localparam logic [CNT_W-1:0] CELLS_C   = CNT_W'(CELLS);

    logic [SIZE_W-1:0] block_size_reg;
    logic [CNT_W-1:0]  num_blocks_reg;
    logic [CNT_W-1:0]  depth_reg;
    logic [CNT_W-1:0]  depth_next;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [OFS_W-1:0]  out_offset_reg;
    logic [1:0]        out_status_reg;
    logic [CNT_W-1:0]  out_used_reg;

    logic [IDX_W-1:0]  res_index;
    logic [1:0]        res_status;
    logic [CNT_W-1:0]  n_eff;
    logic [IDX_W-1:0]  top_idx;
    logic [OFS_W-1:0]  product;
    logic              fire;
    stack_ctrl_t       ctrl;

    assign n_eff    = (num_blocks_reg > CELLS_C) ? CELLS_C : num_blocks_reg;
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    always_comb
    begin
        ctrl       = '0;
        depth_next = depth_reg;
        used_next  = used_reg;
        res_index  = '0;
        res_status = ST_OK;
        case (s_tuser)
            ACT_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    res_status = ST_OOM;
                end
                else
                begin
                    ctrl.pop   = 1'b1;
                    res_index  = top_idx;
                    depth_next = depth_reg - CNT_W'(1);
                    if (used_reg != CNT_W'(CNT_MAX))
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                end
            end
            ACT_FREE:
            begin
                if (depth_reg >= n_eff)
                begin
                    res_status = ST_FULL;
                end
                else if ({1'b0, s_tdata} >= n_eff)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    ctrl.push  = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - CNT_W'(1);
                    end
                end
            end
            ACT_CLEAR:
            begin
                ctrl.load  = 1'b1;
                depth_next = n_eff;
                used_next  = '0;
            end
            ACT_NOP:
            begin
                res_status = ST_OK;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
        if (!fire)
        begin
            ctrl = '0;
        end
    end

    assign product = OFS_W'(res_index) * OFS_W'(block_size_reg);

    fbfl_stack #(
        .CELLS   (CELLS),
        .RST_CNT (RST_CNT)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .n_eff    (n_eff),
        .push_idx (s_tdata),
        .top_idx  (top_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= SIZE_W'(64);
            num_blocks_reg <= CNT_W'(256);
            depth_reg      <= RST_DEPTH;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BLOCK_SIZE)
                begin
                    block_size_reg <= cfg_data;
                end
                else
                begin
                    num_blocks_reg <= cfg_data[CNT_W-1:0];
                end
            end
            if (fire)
            begin
                depth_reg     <= depth_next;
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_index_reg  <= res_index;
            out_offset_reg <= product;
            out_status_reg <= res_status;
            out_used_reg   <= used_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_used_reg, out_offset_reg, out_index_reg};
    assign m_tuser  = out_status_reg;

endmodule
